FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check violated");

`endif

FILE: hw/rtl/mamb_pkg.sv
// Package for the moving average / median blend unit: register map, widths, states.
`default_nettype none

package mamb_pkg;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 6;
	localparam int WLEN_W    = 6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_ENABLE = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/moving_average_median_blend_unit.sv
// Top level of the moving average filter with optional median-of-three blend.
//
//  channel  direction  handshake                fields
//  -------  ---------  -----------------------  ---------------------------
//  in       input      in_valid / in_stall      sample   (SAMPLE_BITS, signed)
//  out      output     out_valid / out_stall    filtered (SAMPLE_BITS, signed)
//  cfg      input      cfg_we (no handshake)    cfg_index, cfg_data
//
// A new word is taken only in ST_IDLE, after the previous result has gone to
// the output register; each word passes ST_READ, ST_LOAD, ST_DIV and ST_DONE
// in turn, and the bit-serial restoring divider, one quotient bit a cycle, runs
// in ST_DIV. Reset clears the history and loads window 1, median off; no
// clearing pass. A result waiting on out_stall does not block the next input
// word; the sequencer holds in ST_DONE only when a second result meets a full
// output.
`default_nettype none

`include "assert_macros.svh"

module moving_average_median_blend_unit
	import mamb_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed      [SAMPLE_BITS-1:0] filtered,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_W-1:0]       cfg_data
);

	localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int TOTAL_W = SAMPLE_BITS + SLOT_W;
	localparam int BIT_W   = $clog2(TOTAL_W);

	// Median of three, ties give the shared value
	function automatic logic signed [SAMPLE_BITS-1:0] median3(
		input logic signed [SAMPLE_BITS-1:0] a,
		input logic signed [SAMPLE_BITS-1:0] b,
		input logic signed [SAMPLE_BITS-1:0] c
	);
		logic signed [SAMPLE_BITS-1:0] m;
		if ((a <= b && b <= c) || (c <= b && b <= a)) begin
			m = b;
		end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
			m = a;
		end else begin
			m = c;
		end
		return m;
	endfunction

	state_t state_q, state_d;

	// configuration and history
	logic        [WLEN_W-1:0]      window_q;
	logic                          median_en_q;
	logic        [SLOT_W-1:0]      slot_q;
	logic        [CNT_W-1:0]       held_q;
	logic signed [TOTAL_W-1:0]     total_q;
	logic signed [SAMPLE_BITS-1:0] prev1_q, prev2_q;

	// per-word working registers
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] med_q;
	logic                          use_med_q;
	logic                          neg_q;
	logic        [TOTAL_W-1:0]     dq_q;
	logic        [CNT_W-1:0]       rem_q;
	logic        [BIT_W-1:0]       bit_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic        [CNT_W-1:0]       win;
	logic                          in_accept;
	logic                          out_free;
	logic                          evict;
	logic        [CNT_W-1:0]       held_new;
	logic signed [TOTAL_W-1:0]     total_new;
	logic        [SLOT_W-1:0]      slot_next;
	logic signed [SAMPLE_BITS-1:0] ring_rdata;
	logic        [CNT_W:0]         trial;
	logic                          trial_ge;
	logic signed [SAMPLE_BITS:0]   mean;
	logic signed [SAMPLE_BITS:0]   blend_sum;
	logic signed [SAMPLE_BITS-1:0] result;

	// Effective window: zero or beyond the ring acts as one
	always_comb begin
		if (window_q == '0 || 32'(window_q) > 32'(WINDOW_DEPTH)) begin
			win = CNT_W'(1);
		end else begin
			win = CNT_W'(window_q);
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	// Sample ring; read at the current slot every cycle, written in ST_READ
	mamb_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_READ),
		.waddr(slot_q),
		.wdata(sample_q),
		.raddr(slot_q),
		.rdata(ring_rdata)
	);

	// History update for the word in flight
	always_comb begin
		evict     = (held_q >= win);
		held_new  = evict ? held_q : held_q + CNT_W'(1);
		total_new = total_q + TOTAL_W'(sample_q)
			- (evict ? TOTAL_W'(ring_rdata) : TOTAL_W'(0));
		if ((CNT_W'(slot_q) + CNT_W'(1)) == win) begin
			slot_next = '0;
		end else begin
			slot_next = slot_q + SLOT_W'(1);
		end
	end

	// Divider step: one quotient bit per cycle
	always_comb begin
		trial    = {rem_q, dq_q[TOTAL_W-1]};
		trial_ge = (trial >= {1'b0, held_q});
	end

	// Sign the quotient and blend with the median
	always_comb begin
		mean      = neg_q ? -signed'(dq_q[SAMPLE_BITS:0]) : signed'(dq_q[SAMPLE_BITS:0]);
		blend_sum = mean + (SAMPLE_BITS + 1)'(med_q);
		result    = use_med_q ? blend_sum[SAMPLE_BITS:1] : mean[SAMPLE_BITS-1:0];
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (bit_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and history registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WLEN_W'(1);
			median_en_q <= 1'b0;
			slot_q      <= '0;
			held_q      <= '0;
			total_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_q    <= cfg_data[WLEN_W-1:0];
				REG_MEDIAN_ENABLE: median_en_q <= cfg_data[0];
				default: ;
			endcase
			slot_q  <= '0;
			held_q  <= '0;
			total_q <= '0;
		end else if (state_q == ST_READ) begin
			slot_q  <= slot_next;
			held_q  <= held_new;
			total_q <= total_new;
		end
	end

	// Working registers: capture, median, divider
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= sample;
		end
		if (state_q == ST_READ) begin
			med_q     <= median3(sample_q, prev1_q, prev2_q);
			use_med_q <= median_en_q && (held_new >= CNT_W'(3));
			prev1_q   <= sample_q;
			prev2_q   <= prev1_q;
		end
		if (state_q == ST_LOAD) begin
			neg_q <= total_q[TOTAL_W-1];
			dq_q  <= total_q[TOTAL_W-1] ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);
			rem_q <= '0;
			bit_q <= BIT_W'(TOTAL_W - 1);
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, held_q}) : trial[CNT_W-1:0];
			dq_q  <= {dq_q[TOTAL_W-2:0], trial_ge};
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			filtered_q <= result;
		end
	end

	// Checks
	`CHK_ALWAYS(a_held_in_window, clk, arst_n, held_q <= win)
	`CHK_ALWAYS(a_slot_in_window, clk, arst_n, CNT_W'(slot_q) < win)
	`CHK_NEXT(a_accept_starts, clk, arst_n, in_accept, state_q == ST_READ)
	`CHK_ALWAYS(a_result_from_done, clk, arst_n, !$rose(out_valid_q) || $past(state_q) == ST_DONE)

endmodule

`default_nettype wire

FILE: hw/rtl/mamb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mamb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
